// ----- src/trie_path_edit_distance_rows_core_defines.svh -----
// ----------------------------------------------------------------------------
// Trie path edit distance row engine: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIE_PATH_EDIT_DISTANCE_ROWS_CORE_DEFINES_SVH
`define TRIE_PATH_EDIT_DISTANCE_ROWS_CORE_DEFINES_SVH

// Same-cycle implication.
`define TPEDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TPEDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tpedr_pkg.sv -----
// ----------------------------------------------------------------------------
// Trie path edit distance row engine: package
// Field widths, codes, the cell operand bundle and saturating arithmetic.
// ----------------------------------------------------------------------------
package tpedr_pkg;

  localparam int DIST_W  = 7;
  localparam int BAND_W  = 6;
  localparam int CHAR_W  = 8;
  localparam int FREQ_W  = 32;
  localparam int MAXD_W  = 5;
  localparam int QLEN_W  = 6;
  localparam int CMP_W   = 8;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 48;
  localparam int CFG_W   = 6;

  localparam logic [DIST_W-1:0] DIST_SAT = '1;
  localparam logic [BAND_W-1:0] BAND_SAT = '1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic CFG_MAX_DISTANCE = 1'b0;
  localparam logic CFG_QUERY_LENGTH = 1'b1;

  // Operands of one distance cell.
  typedef struct packed {
    logic              first;
    logic              trans_ok;
    logic [DIST_W-1:0] prev_i;
    logic [DIST_W-1:0] prev_im1;
    logic [DIST_W-1:0] cur_im1;
    logic [DIST_W-1:0] prev2_im2;
    logic [CHAR_W-1:0] q_im1;
    logic [CHAR_W-1:0] q_im2;
    logic [CHAR_W-1:0] letter;
    logic [CHAR_W-1:0] prevl;
  } cell_in_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, DIST_SAT}) ? DIST_SAT : s[DIST_W-1:0];
  endfunction

endpackage

// ----- src/trie_path_edit_distance_rows_core.sv -----
// ----------------------------------------------------------------------------
// Trie path edit distance row engine
// Banded restricted Damerau-Levenshtein rows for a depth-first trie walk.
// ----------------------------------------------------------------------------
// Channel  Direction  Carries
// in_      slave      load query character or trie letter step (kind in tuser)
// out_     master     distance, row minimum, accept, descend, frequency
// cfg_     write      max_distance (index 0), query_length (index 1)
//
// A load item or a step with a depth out of range skips the row sweep and goes
// straight to the result stage. For a trie step the row is swept one column a
// cycle through a single cell unit, with one distance memory read per column on
// each of two copies, since a transposition needs the second previous row too.
// Rows carry valid flags, so reset needs no clearing pass.
// A result waiting on out_tready does not block the next request from entering.
// ----------------------------------------------------------------------------
`include "trie_path_edit_distance_rows_core_defines.svh"

module trie_path_edit_distance_rows_core
  import tpedr_pkg::*;
#(
  parameter int MAX_QUERY = 32,
  parameter int MAX_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // position, query_char, depth, path_letter, word_end, word_freq
  input  logic [IN_W-1:0]  in_tdata,
  // kind
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // distance, row_min, accept, descend, match_freq
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW  = $clog2(MAX_QUERY + 2);
  localparam int RW  = $clog2(MAX_DEPTH + 1);
  localparam int AW  = RW + CW;
  localparam int QAW = $clog2(MAX_QUERY);
  localparam int PW  = $clog2(MAX_DEPTH);
  localparam logic [CW-1:0] BAND_COL = CW'(MAX_QUERY + 1);
  localparam logic [CW-1:0] LAST_COL = CW'(MAX_QUERY);

  typedef enum logic [2:0] {ST_IDLE, ST_BAND, ST_SWEEP, ST_BWR, ST_FIN} state_t;

  state_t state_r, state_nxt;

  logic [MAXD_W-1:0] max_distance_r;
  logic [QLEN_W-1:0] query_length_r;
  logic [MAX_DEPTH:0] valid_r;
  logic [RW-1:0]     row_d_r, row_p1_r, row_p2_r;
  logic              d2_r;
  logic              zero_r;
  logic [CW-1:0]     len_r, c_r;
  logic [BAND_W-1:0] cb_r;
  logic              cb_le_len_r;
  logic [CHAR_W-1:0] letter_r, prevl_r, q_im2_r;
  logic [DIST_W-1:0] prev_im1_r, cur_im1_r, rmin_r, dist_r, curcb_r;
  logic              wend_r;
  logic [FREQ_W-1:0] freq_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  // Request fields.
  logic              in_kind;
  logic [4:0]        in_position;
  logic [CHAR_W-1:0] in_query_char;
  logic [5:0]        in_depth;
  logic [CHAR_W-1:0] in_path_letter;
  logic              in_word_end;
  logic [FREQ_W-1:0] in_word_freq;

  assign in_kind        = in_tuser;
  assign in_position    = in_tdata[4:0];
  assign in_query_char  = in_tdata[12:5];
  assign in_depth       = in_tdata[18:13];
  assign in_path_letter = in_tdata[26:19];
  assign in_word_end    = in_tdata[27];
  assign in_word_freq   = in_tdata[59:28];

  logic in_acc, depth_ok, step_ok;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign depth_ok  = (in_depth != '0) && (7'(in_depth) <= 7'(MAX_DEPTH));
  assign step_ok   = (in_kind == KIND_STEP) && depth_ok;

  // Memory ports.
  logic [AW-1:0]     a_raddr, b_raddr, d_waddr;
  logic              d_we;
  logic [DIST_W-1:0] d_wdata, rd_a, rd_b;
  logic              q_we;
  logic [QAW-1:0]    q_waddr, q_raddr;
  logic [CHAR_W-1:0] q_rdata;
  logic              p_we;
  logic [PW-1:0]     p_waddr, p_raddr;
  logic [CHAR_W-1:0] p_rdata;

  // Datapath.
  logic [CW-1:0]     col_a, col_b;
  logic [DIST_W-1:0] pa_val, pb_val;
  logic [CMP_W-1:0]  i_x, cb_x, cbv_x, len_x, nb_x;
  logic [BAND_W-1:0] nb;
  logic              in_band, first, at_len;
  cell_in_t          cin;
  logic [DIST_W-1:0] cost, w_val;
  logic              out_load;
  logic [DIST_W-1:0] dist_o, rmin_o;
  logic              acc_o, desc_o;
  logic [FREQ_W-1:0] mf_o;

  // Rows that were never written read as their reset contents.
  function automatic logic [DIST_W-1:0] map_rd(input logic vld, input logic row0,
                                               input logic bandc,
                                               input logic [CW-1:0] col,
                                               input logic [DIST_W-1:0] raw);
    if (vld) return raw;
    else if (bandc) return '0;
    else if (row0) return DIST_W'(col);
    else return DIST_SAT;
  endfunction

  always_comb begin
    col_a  = (state_r == ST_BAND) ? BAND_COL : c_r;
    col_b  = c_r - CW'(2);
    pa_val = map_rd(valid_r[row_p1_r], row_p1_r == '0, state_r == ST_BAND, col_a, rd_a);
    pb_val = map_rd(valid_r[row_p2_r], row_p2_r == '0, 1'b0, col_b, rd_b);

    i_x    = CMP_W'(c_r);
    cb_x   = CMP_W'(cb_r);
    cbv_x  = CMP_W'(pa_val[BAND_W-1:0]);
    len_x  = CMP_W'(len_r);
    in_band = cb_le_len_r && (i_x >= cb_x) && (i_x <= len_x);
    first   = (i_x == cb_x);
    at_len  = (i_x == len_x);

    cin.first     = first;
    cin.trans_ok  = d2_r && (i_x > CMP_W'(1));
    cin.prev_i    = pa_val;
    cin.prev_im1  = prev_im1_r;
    cin.cur_im1   = cur_im1_r;
    cin.prev2_im2 = pb_val;
    cin.q_im1     = q_rdata;
    cin.q_im2     = q_im2_r;
    cin.letter    = letter_r;
    cin.prevl     = prevl_r;

    w_val = in_band ? cost : DIST_SAT;

    // The band moves on once its first cell has gone over the limit.
    nb_x = cb_x + CMP_W'(curcb_r > DIST_W'(max_distance_r));
    if (!cb_le_len_r) nb = cb_r;
    else if (nb_x > CMP_W'(BAND_SAT)) nb = BAND_SAT;
    else nb = nb_x[BAND_W-1:0];

    dist_o = zero_r ? '0 : dist_r;
    rmin_o = zero_r ? '0 : rmin_r;
    acc_o  = !zero_r && wend_r && (freq_r != '0) && (dist_r <= DIST_W'(max_distance_r));
    desc_o = !zero_r && (rmin_r <= DIST_W'(max_distance_r));
    mf_o   = acc_o ? freq_r : '0;
    out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

    // Read addresses: band word at acceptance, then one column ahead of the cell unit.
    a_raddr = {row_p1_r, c_r + CW'(1)};
    b_raddr = {row_p2_r, c_r - CW'(1)};
    q_raddr = QAW'(c_r);
    if (state_r == ST_IDLE) begin
      a_raddr = {RW'(in_depth - 6'd1), BAND_COL};
    end else if (state_r == ST_BAND) begin
      a_raddr = {row_p1_r, CW'(0)};
    end

    d_we    = (state_r == ST_SWEEP) || (state_r == ST_BWR);
    d_waddr = {row_d_r, (state_r == ST_SWEEP) ? c_r : BAND_COL};
    d_wdata = (state_r == ST_SWEEP) ? w_val : DIST_W'(nb);

    q_we    = in_acc && (in_kind == KIND_LOAD) && (7'(in_position) < 7'(MAX_QUERY));
    q_waddr = QAW'(in_position);

    p_we    = in_acc && step_ok;
    p_waddr = PW'(in_depth - 6'd1);
    p_raddr = PW'(in_depth - 6'd2);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = step_ok ? ST_BAND : ST_FIN;
      end
      ST_BAND:  state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (c_r == LAST_COL) state_nxt = ST_BWR;
      end
      ST_BWR:   state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      valid_r        <= '0;
      max_distance_r <= MAXD_W'(2);
      query_length_r <= QLEN_W'(1);
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_DISTANCE: max_distance_r <= cfg_wdata[MAXD_W-1:0];
          CFG_QUERY_LENGTH: query_length_r <= cfg_wdata[QLEN_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_tdata_r <= {mf_o, desc_o, acc_o, rmin_o, dist_o};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            zero_r   <= !step_ok;
            letter_r <= in_path_letter;
            wend_r   <= in_word_end;
            freq_r   <= in_word_freq;
            len_r    <= (7'(query_length_r) > 7'(MAX_QUERY)) ? CW'(MAX_QUERY)
                                                             : CW'(query_length_r);
            if (step_ok) begin
              row_d_r  <= RW'(in_depth);
              row_p1_r <= RW'(in_depth - 6'd1);
              row_p2_r <= (in_depth >= 6'd2) ? RW'(in_depth - 6'd2) : '0;
              d2_r     <= (in_depth >= 6'd2);
            end
          end
        end
        ST_BAND: begin
          cb_r        <= pa_val[BAND_W-1:0];
          cb_le_len_r <= (cbv_x <= len_x);
          prevl_r     <= p_rdata;
          rmin_r      <= DIST_SAT;
          dist_r      <= DIST_SAT;
          c_r         <= '0;
        end
        ST_SWEEP: begin
          prev_im1_r <= pa_val;
          cur_im1_r  <= w_val;
          q_im2_r    <= q_rdata;
          c_r        <= c_r + CW'(1);
          if (in_band) begin
            if (cost < rmin_r) rmin_r <= cost;
            if (first) curcb_r <= cost;
            if (at_len) dist_r <= cost;
          end
        end
        ST_BWR: begin
          valid_r[row_d_r] <= 1'b1;
        end
        ST_FIN: ;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  tpedr_cell u_cell (
    .cin  (cin),
    .cost (cost)
  );

  // Two identical copies give the previous and the second previous row together.
  tpedr_ram #(.WIDTH(DIST_W), .DEPTH(2 ** AW)) u_rows_a (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (a_raddr),
    .rdata (rd_a)
  );

  tpedr_ram #(.WIDTH(DIST_W), .DEPTH(2 ** AW)) u_rows_b (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (b_raddr),
    .rdata (rd_b)
  );

  tpedr_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_QUERY)) u_query (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (in_query_char),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  tpedr_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_DEPTH)) u_path (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (in_path_letter),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  `TPEDR_ASSERT_IMP(a_rowmin_le_dist, out_tvalid, out_tdata[13:7] <= out_tdata[6:0], "row minimum above distance")
  `TPEDR_ASSERT_IMP(a_freq_with_accept, out_tvalid, out_tdata[14] == (out_tdata[47:16] != '0), "frequency does not follow accept")
  `TPEDR_ASSERT_IMP(a_sweep_bound, state_r == ST_SWEEP, CMP_W'(c_r) <= CMP_W'(MAX_QUERY), "column sweep overran")
  `TPEDR_ASSERT_NXT(a_row_marked, state_r == ST_BWR, valid_r[row_d_r], "written row not marked valid")

endmodule

// ----- src/tpedr_ram.sv -----
// ----------------------------------------------------------------------------
// Trie path edit distance row engine: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tpedr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tpedr_cell.sv -----
// ----------------------------------------------------------------------------
// Trie path edit distance row engine: cell unit
// Computes one restricted Damerau-Levenshtein cell from its neighbours.
// ----------------------------------------------------------------------------
module tpedr_cell
  import tpedr_pkg::*;
(
  input  cell_in_t          cin,
  output logic [DIST_W-1:0] cost
);

  logic [DIST_W-1:0] sub;
  logic [DIST_W-1:0] ins_c;
  logic [DIST_W-1:0] del_c;
  logic [DIST_W-1:0] rep_c;
  logic [DIST_W-1:0] tr_c;
  logic [DIST_W-1:0] best;
  logic              swap;

  always_comb begin
    sub   = DIST_W'(cin.q_im1 != cin.letter);
    ins_c = sat_add(cin.cur_im1, DIST_W'(1));
    del_c = sat_add(cin.prev_i, DIST_W'(1));
    rep_c = sat_add(cin.prev_im1, sub);
    tr_c  = sat_add(cin.prev2_im2, sub);
    swap  = cin.trans_ok && (cin.q_im1 == cin.prevl) && (cin.q_im2 == cin.letter);

    best = ins_c;
    if (del_c < best) best = del_c;
    if (rep_c < best) best = rep_c;
    if (swap && (tr_c < best)) best = tr_c;

    // The first cell of the band only looks straight up.
    cost = cin.first ? del_c : best;
  end

endmodule

// ----- sim/tb_trie_path_edit_distance_rows_core.sv -----
// ----------------------------------------------------------------------------
// Testbench: trie path edit distance row engine
// Loads a query, then drives depth-first trie walks with random letters,
// word ends and frequencies under several limit and length settings. Every
// accepted request is run through a local row predictor and each result is
// compared field by field with the oldest prediction, under random stalls on
// both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_trie_path_edit_distance_rows_core;
  import tpedr_pkg::*;

  localparam int QMAX       = 32;
  localparam int DMAX       = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_LEN   = 500;
  localparam int NPHASE     = 7;

  typedef struct packed {
    logic              kind;
    logic [4:0]        position;
    logic [CHAR_W-1:0] query_char;
    logic [5:0]        depth;
    logic [CHAR_W-1:0] path_letter;
    logic              word_end;
    logic [FREQ_W-1:0] word_freq;
  } trie_req_t;

  localparam int REQ_W = $bits(trie_req_t);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] row_min;
    logic              accept;
    logic              descend;
    logic [FREQ_W-1:0] freq;
  } edit_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  trie_req_t    trie_requests_q[$];
  edit_result_t edit_results_q[$];
  trie_req_t    cur_req = '0;
  int           fails = 0;
  int           send_idle_pct = 11;
  int           recv_idle_pct = 65;
  int           idle_cycles = 0;
  int           hold_left = 0;
  logic         hold_req = 1'b0;

  // Predictor state.
  logic [CHAR_W-1:0] query_chars [QMAX];
  logic [CHAR_W-1:0] path_chars  [DMAX];
  logic [DIST_W-1:0] rows        [DMAX+1][QMAX+1];
  logic [BAND_W-1:0] band        [DMAX+1];
  logic [MAXD_W-1:0] max_lim;
  logic [QLEN_W-1:0] qlen;

  // Stimulus-side view of the loaded query and the walk position.
  logic [CHAR_W-1:0] gen_query [QMAX];
  int                walk_depth = 0;

  trie_path_edit_distance_rows_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int sat_sum(input int a, input int b);
    return (a + b > int'(DIST_SAT)) ? int'(DIST_SAT) : a + b;
  endfunction

  function automatic int min2(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic void reset_model();
    for (int d = 0; d <= DMAX; d++) begin
      band[d] = '0;
      for (int i = 0; i <= QMAX; i++)
        rows[d][i] = (d == 0) ? DIST_W'(i) : DIST_SAT;
    end
    for (int i = 0; i < QMAX; i++) query_chars[i] = '0;
    for (int i = 0; i < DMAX; i++) path_chars[i] = '0;
    max_lim = 5'd2;
    qlen = 6'd1;
  endfunction

  // Computes a trie step's row, updating rows and band; a load stores its char.
  function automatic edit_result_t compute_edit_row(input trie_req_t rq);
    edit_result_t r;
    int len, cb, d, v, t, rmin, nb, dist_v;
    logic [CHAR_W-1:0] prev_letter;
    r = '0;
    if (rq.kind == KIND_LOAD) begin
      query_chars[rq.position] = rq.query_char;
      return r;
    end
    d = rq.depth;
    if (d == 0 || d > DMAX) return r;
    len = (qlen > QMAX) ? QMAX : qlen;
    cb = band[d-1];
    prev_letter = (d >= 2) ? path_chars[d-2] : '0;
    path_chars[d-1] = rq.path_letter;
    for (int i = 0; i <= QMAX; i++) rows[d][i] = DIST_SAT;
    if (cb > len) begin
      band[d] = BAND_W'(cb);
      r.distance = DIST_SAT;
      r.row_min = DIST_SAT;
      return r;
    end
    rows[d][cb] = DIST_W'(sat_sum(rows[d-1][cb], 1));
    rmin = rows[d][cb];
    for (int i = cb + 1; i <= len; i++) begin
      t = (query_chars[i-1] == rq.path_letter) ? 0 : 1;
      v = sat_sum(rows[d][i-1], 1);
      v = min2(v, sat_sum(rows[d-1][i], 1));
      v = min2(v, sat_sum(rows[d-1][i-1], t));
      // Adjacent transposition of the last two path letters.
      if (i > 1 && d >= 2 && query_chars[i-1] == prev_letter
          && query_chars[i-2] == rq.path_letter)
        v = min2(v, sat_sum(rows[d-2][i-2], t));
      rows[d][i] = DIST_W'(v);
      rmin = min2(rmin, v);
    end
    dist_v = rows[d][len];
    nb = (rows[d][cb] <= max_lim) ? cb : cb + 1;
    if (nb > int'(BAND_SAT)) nb = int'(BAND_SAT);
    band[d] = BAND_W'(nb);
    r.distance = DIST_W'(dist_v);
    r.row_min = DIST_W'(rmin);
    r.accept = rq.word_end && rq.word_freq != 0 && dist_v <= max_lim;
    r.descend = rmin <= max_lim;
    r.freq = r.accept ? rq.word_freq : '0;
    return r;
  endfunction

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fails++;
    end
  endtask

  // Driver: presents queued requests and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) edit_results_q.push_back(compute_edit_row(cur_req));
      if (!in_tvalid || in_tready) begin
        if (trie_requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req  <= trie_requests_q[0];
          in_tdata <= {4'b0, trie_requests_q[0].word_freq, trie_requests_q[0].word_end,
                       trie_requests_q[0].path_letter, trie_requests_q[0].depth,
                       trie_requests_q[0].query_char, trie_requests_q[0].position};
          in_tuser <= trie_requests_q[0].kind;
          void'(trie_requests_q.pop_front());
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and drives out_tready, including the long hold-off.
  always @(posedge clk) begin
    edit_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (edit_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          fails++;
        end else begin
          want = edit_results_q.pop_front();
          check_field("distance",   want.distance, out_tdata[6:0]);
          check_field("row_min",    want.row_min,  out_tdata[13:7]);
          check_field("accept",     want.accept,   out_tdata[14]);
          check_field("descend",    want.descend,  out_tdata[15]);
          check_field("match_freq", want.freq,     out_tdata[47:16]);
        end
      end
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_req) hold_left <= HOLD_LEN;
      out_tready <= hold_left == 0 && !hold_req && $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Watchdog on cycles with no request, result or register write.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [CHAR_W-1:0] pick_char();
    return ($urandom_range(99) < 80) ? CHAR_W'($urandom_range(8'h64, 8'h61))
                                     : CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    int r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 30) return '1;
    return $urandom;
  endfunction

  task automatic push_load(input int pos, input logic [CHAR_W-1:0] ch);
    trie_req_t rq;
    rq = REQ_W'({$urandom, $urandom});
    rq.kind = KIND_LOAD;
    rq.position = pos[4:0];
    rq.query_char = ch;
    gen_query[pos] = ch;
    trie_requests_q.push_back(rq);
  endtask

  task automatic push_step(input int d, input logic [CHAR_W-1:0] letter,
                           input logic wend, input logic [FREQ_W-1:0] freq);
    trie_req_t rq;
    rq = REQ_W'({$urandom, $urandom});
    rq.kind = KIND_STEP;
    rq.depth = d[5:0];
    rq.path_letter = letter;
    rq.word_end = wend;
    rq.word_freq = freq;
    trie_requests_q.push_back(rq);
  endtask

  // Random depth-first walk: mostly descents that follow the query, with
  // backtracking, swapped letter pairs, stray loads and bad depths as noise.
  task automatic gen_walk(input int n);
    int cnt, r, d;
    logic [CHAR_W-1:0] letter;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        push_step($urandom_range(1) ? 0 : $urandom_range(63, DMAX + 1),
                  CHAR_W'($urandom), 1'($urandom_range(1)), pick_freq());
        cnt++;
      end else if (r < 8) begin
        push_load($urandom_range(QMAX - 1), pick_char());
        cnt++;
      end else if (r < 20 && walk_depth <= DMAX - 2) begin
        d = walk_depth + 1;
        push_step(d, gen_query[d], 1'($urandom_range(1)), pick_freq());
        push_step(d + 1, gen_query[d-1], 1'($urandom_range(1)), pick_freq());
        walk_depth = d + 1;
        cnt += 2;
      end else begin
        if (walk_depth < DMAX && $urandom_range(99) < 70) d = walk_depth + 1;
        else d = $urandom_range(walk_depth, 1);
        r = $urandom_range(99);
        if (r < 55) letter = gen_query[d-1];
        else if (r < 75) letter = pick_char();
        else letter = CHAR_W'($urandom_range(255));
        push_step(d, letter, 1'($urandom_range(1)), pick_freq());
        walk_depth = d;
        cnt++;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_DISTANCE) max_lim = val[MAXD_W-1:0];
    else qlen = val;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (trie_requests_q.size() != 0 || in_tvalid || edit_results_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int md_set [NPHASE];
    int ql_set [NPHASE];
    md_set = '{2, 0, 31, 3, 1, 2, 31};
    ql_set = '{1, 32, 8, 0, 63, 6, 32};
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < QMAX; i++) push_load(i, pick_char());
    push_load(QMAX - 2, 8'h00);
    push_load(QMAX - 1, 8'hFF);

    // Directed: bad depths, then a walk that runs the band past a short query.
    push_step(0, 8'h00, 1'b1, '1);
    push_step(63, 8'hFF, 1'b1, '1);
    push_step(DMAX + 1, 8'h61, 1'b1, 32'd1);
    push_step(1, gen_query[0], 1'b1, '1);
    push_step(2, 8'hFF, 1'b1, '0);
    push_step(3, 8'h00, 1'b0, 32'd5);
    push_step(4, gen_query[0], 1'b1, 32'd7);
    push_step(5, gen_query[0], 1'b1, 32'd9);
    push_step(6, 8'h62, 1'b1, '1);
    push_step(1, 8'hFF, 1'b1, 32'd3);
    push_step(2, gen_query[0], 1'b1, '1);
    push_step(1, gen_query[0], 1'b0, '1);
    walk_depth = 1;

    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(CFG_MAX_DISTANCE, CFG_W'(md_set[ph]));
        write_reg(CFG_QUERY_LENGTH, CFG_W'(ql_set[ph]));
      end
      @(posedge clk);
      send_idle_pct <= (ph < 3) ? 11 : (ph < 5) ? 65 : 0;
      recv_idle_pct <= (ph < 3) ? 65 : (ph < 5) ? 11 : 0;
      if (ph == 5) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      // A straight dive to the deepest level with the full query in use.
      if (ph == 1 || ph == 6) begin
        for (int d = 1; d <= DMAX; d++)
          push_step(d, ($urandom_range(3) != 0) ? gen_query[d-1] : pick_char(),
                    1'($urandom_range(1)), pick_freq());
        walk_depth = DMAX;
      end
      gen_walk(52);
    end
    drain();
    repeat (40) @(negedge clk);

    if (fails == 0 && edit_results_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
